// ----- design/rrfp_pkg.sv -----
// ============================================================================
// rrfp_pkg
// Shared constants, codes and types of the radar report frame parser.
// ============================================================================
package rrfp_pkg;

    // Body store geometry
    localparam int BODY_BYTES = 64;
    localparam int ADDR_W     = $clog2(BODY_BYTES);
    localparam int FILL_W     = $clog2(BODY_BYTES + 1);
    localparam int TAIL_LEN   = 4;
    localparam int REM_W      = $clog2(BODY_BYTES + TAIL_LEN + 1);

    // Gate counts
    localparam int MAX_GATE = 8;
    localparam int GATE_W   = 4;

    // Fixed body layout: bytes 0..12 are kept in flops as they arrive
    localparam int HDR_BYTES = 13;
    localparam int HDR_IDX_W = $clog2(HDR_BYTES);
    localparam int BASIC_MIN = 11;
    localparam int ENH_MIN   = 13;
    localparam int ENH_FIXED = 17;  // 13 fixed bytes, two count offsets, light, out

    // Frame markers
    localparam logic [3:0][7:0] HEAD_PAT = {8'hF1, 8'hF2, 8'hF3, 8'hF4};
    localparam logic [3:0][7:0] TAIL_PAT = {8'hF5, 8'hF6, 8'hF7, 8'hF8};
    localparam logic [7:0]      MARKER   = 8'hAA;
    localparam logic [7:0]      TYPE_ENH = 8'd1;
    localparam logic [7:0]      TYPE_BAS = 8'd2;
    localparam logic [2:0]      STATUS_MASK = 3'd7;

    // Record kinds
    localparam logic [2:0] KIND_BASIC  = 3'd0;
    localparam logic [2:0] KIND_ENH    = 3'd1;
    localparam logic [2:0] KIND_MOVING = 3'd2;
    localparam logic [2:0] KIND_STILL  = 3'd3;
    localparam logic [2:0] KIND_REJECT = 3'd4;

    // Reject codes
    localparam logic [2:0] REJ_ZERO_LEN = 3'd0;
    localparam logic [2:0] REJ_TOO_LONG = 3'd1;
    localparam logic [2:0] REJ_TAIL     = 3'd2;
    localparam logic [2:0] REJ_TYPE     = 3'd3;
    localparam logic [2:0] REJ_SHORT    = 3'd4;

    // Frame-end event from the front end to the record sequencer
    typedef struct packed {
        logic                              fire;
        logic                              reject;
        logic [2:0]                        code;
        logic                              enh;
        logic [GATE_W-1:0]                 nm;
        logic [GATE_W-1:0]                 ns;
        logic [HDR_BYTES-1:0][7:0]         hdr;
    } ev_t;

    // One result record
    typedef struct packed {
        logic [2:0]        kind;
        logic [2:0]        status;
        logic [15:0]       moving_distance;
        logic [7:0]        moving_energy;
        logic [15:0]       still_distance;
        logic [7:0]        still_energy;
        logic [15:0]       detect_distance;
        logic [7:0]        light_level;
        logic [7:0]        out_level;
        logic [GATE_W-1:0] gate_index;
        logic [7:0]        gate_energy;
        logic              last;
    } rec_t;

endpackage

// ----- design/radar_report_frame_parser.sv -----
// Records: a frame-ending byte moves the sequencer to E_REJ (reject), E_SUM (basic)
//   or E_L_RD, E_L_CAP, E_O_CAP, E_SUM (enhanced); each gate record takes E_G_RD, E_G_OUT.
// Throughput: 1 byte per cycle; input stalls while a frame's records are sequenced, and
//   the single read port of the body store gives one gate energy at a time.
// Reset: rst_n asynchronous, active low; clears the window, phase, counters and output
//   valid. The body store is not cleared; entries are read only after being written.
// ============================================================================
// radar_report_frame_parser
// Parses length-prefixed radar report frames from a byte stream into records.
// ============================================================================
module radar_report_frame_parser
    import rrfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] target_status, [18:3] moving_distance, [26:19] moving_energy,
    // [42:27] still_distance, [50:43] still_energy, [66:51] detect_distance,
    // [74:67] light_level, [82:75] out_level, [86:83] gate_index,
    // [94:87] gate_energy, [95] zero
    output logic [95:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] result_kind
    output logic        m_axis_tlast
);

    logic              accept;
    logic              busy;
    ev_t               ev;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    rec_t              rec;

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    rrfp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_axis_tdata),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .ev      (ev)
    );

    rrfp_body_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rrfp_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev        (ev),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (rec)
    );

    // Output word packing
    assign m_axis_tdata = {1'b0, rec.gate_energy, rec.gate_index, rec.out_level,
                           rec.light_level, rec.detect_distance, rec.still_energy,
                           rec.still_distance, rec.moving_energy, rec.moving_distance,
                           rec.status};
    assign m_axis_tuser = rec.kind;
    assign m_axis_tlast = rec.last;

endmodule

// ----- design/rrfp_body_ram.sv -----
// ============================================================================
// rrfp_body_ram
// Body byte store: one write port, one read port with registered read data.
// ============================================================================
module rrfp_body_ram
    import rrfp_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [BODY_BYTES];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/rrfp_front.sv -----
// ============================================================================
// rrfp_front
// Byte front end: header hunt, length, body capture and frame-end checks.
// ============================================================================
module rrfp_front
    import rrfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output ev_t               ev
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_FRAME
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [3:0][7:0]           win_reg;          // [3] newest
    logic [3:0][7:0]           win_now;          // window including this byte, [0] oldest
    logic [7:0]                len_lo_reg;
    logic [REM_W-1:0]          rem_reg, rem_next, rem_dec;
    logic [FILL_W-1:0]         fill_reg, fill_next;
    logic [HDR_BYTES-1:0][7:0] hdr_reg;
    logic [15:0]               len_full;
    logic                      store;
    logic                      frame_end;
    logic                      len_reject;
    logic [2:0]                len_code;
    logic [2:0]                end_code;
    logic                      end_reject;
    logic                      is_enh;
    logic [GATE_W-1:0]         nm_clamp, ns_clamp;
    logic [FILL_W-1:0]         enh_need;

    // Window as seen after this byte
    always_comb
    begin
        win_now[0] = win_reg[1];
        win_now[1] = win_reg[2];
        win_now[2] = win_reg[3];
        win_now[3] = rx_byte;
    end

    assign len_full = {rx_byte, len_lo_reg};
    assign rem_dec  = (rem_reg != '0) ? rem_reg - REM_W'(1) : rem_reg;
    assign store    = (phase_reg == PH_FRAME) && (rem_reg > REM_W'(TAIL_LEN))
                      && (fill_reg < FILL_W'(BODY_BYTES));

    // Clamped gate counts and enhanced layout length
    assign nm_clamp = (hdr_reg[11] > 8'(MAX_GATE)) ? GATE_W'(MAX_GATE)
                                                   : hdr_reg[11][GATE_W-1:0];
    assign ns_clamp = (hdr_reg[12] > 8'(MAX_GATE)) ? GATE_W'(MAX_GATE)
                                                   : hdr_reg[12][GATE_W-1:0];
    assign enh_need = FILL_W'(ENH_FIXED) + FILL_W'(nm_clamp) + FILL_W'(ns_clamp);
    assign is_enh   = (hdr_reg[0] == TYPE_ENH);

    // Length checks at the second length byte
    always_comb
    begin
        len_reject = 1'b0;
        len_code   = REJ_ZERO_LEN;
        if (len_full == 16'd0)
        begin
            len_reject = 1'b1;
        end
        else if (len_full > 16'(BODY_BYTES))
        begin
            len_reject = 1'b1;
            len_code   = REJ_TOO_LONG;
        end
    end

    // Frame checks at the last tail byte, in priority order
    always_comb
    begin
        end_reject = 1'b1;
        end_code   = REJ_SHORT;
        if (win_now != TAIL_PAT)
        begin
            end_code = REJ_TAIL;
        end
        else if (fill_reg < FILL_W'(2))
        begin
            end_code = REJ_SHORT;
        end
        else if (!(hdr_reg[0] == TYPE_ENH || hdr_reg[0] == TYPE_BAS)
                 || hdr_reg[1] != MARKER)
        begin
            end_code = REJ_TYPE;
        end
        else if (fill_reg < FILL_W'(BASIC_MIN))
        begin
            end_code = REJ_SHORT;
        end
        else if (is_enh && fill_reg < FILL_W'(ENH_MIN))
        begin
            end_code = REJ_SHORT;
        end
        else if (is_enh && fill_reg < enh_need)
        begin
            end_code = REJ_SHORT;
        end
        else
        begin
            end_reject = 1'b0;
        end
    end

    assign frame_end = (phase_reg == PH_FRAME) && (rem_dec == '0);

    // Phase and counters
    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        fill_next  = fill_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (win_now == HEAD_PAT)
                begin
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                if (len_reject)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    rem_next   = REM_W'(len_full) + REM_W'(TAIL_LEN);
                    fill_next  = '0;
                    phase_next = PH_FRAME;
                end
            end
            PH_FRAME:
            begin
                if (store)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                rem_next = rem_dec;
                if (frame_end)
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            win_reg    <= '0;
            len_lo_reg <= '0;
            rem_reg    <= '0;
            fill_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            win_reg   <= {rx_byte, win_reg[3:1]};
            rem_reg   <= rem_next;
            fill_reg  <= fill_next;
            if (phase_reg == PH_LEN_LO)
            begin
                len_lo_reg <= rx_byte;
            end
        end
    end

    // Fixed-position body bytes kept in flops
    always_ff @(posedge clk)
    begin
        if (accept && store && fill_reg < FILL_W'(HDR_BYTES))
        begin
            hdr_reg[fill_reg[HDR_IDX_W-1:0]] <= rx_byte;
        end
    end

    // Body store write
    assign wr_en   = accept && store;
    assign wr_addr = fill_reg[ADDR_W-1:0];
    assign wr_data = rx_byte;

    // Frame-end event
    always_comb
    begin
        ev.fire   = accept && ((phase_reg == PH_LEN_HI && len_reject) || frame_end);
        ev.reject = (phase_reg == PH_LEN_HI) ? 1'b1 : end_reject;
        ev.code   = (phase_reg == PH_LEN_HI) ? len_code : end_code;
        ev.enh    = is_enh;
        ev.nm     = nm_clamp;
        ev.ns     = ns_clamp;
        ev.hdr    = hdr_reg;
    end

endmodule

// ----- design/rrfp_emit.sv -----
// ============================================================================
// rrfp_emit
// Record sequencer: reads the body store and drives the output register.
// ============================================================================
module rrfp_emit
    import rrfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ev_t               ev,
    output logic              busy,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rec_t              out_rec
);

    typedef enum logic [2:0] {
        E_IDLE,
        E_REJ,
        E_L_RD,
        E_L_CAP,
        E_O_CAP,
        E_SUM,
        E_G_RD,
        E_G_OUT
    } est_t;

    est_t              state_reg;
    logic              out_valid_reg;
    rec_t              out_rec_reg;
    logic [2:0]        code_reg;
    logic              enh_reg;
    logic [7:0]        light_reg;
    logic [7:0]        outlvl_reg;
    logic [ADDR_W-1:0] gptr_reg;
    logic [GATE_W-1:0] gidx_reg;
    logic              still_reg;
    logic              out_free;
    logic [ADDR_W-1:0] light_addr;
    logic              gate_last;
    rec_t              rec_sum, rec_gate, rec_rej;

    assign out_free   = !out_valid_reg || out_ready;
    assign light_addr = ADDR_W'(HDR_BYTES + 2) + ADDR_W'(ev.nm) + ADDR_W'(ev.ns);
    assign gate_last  = still_reg && (gidx_reg == ev.ns);

    // Store reads for light, output level and gate energies
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = gptr_reg;
        case (state_reg)
            E_L_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = light_addr;
            end
            E_L_CAP:
            begin
                rd_en   = 1'b1;
                rd_addr = light_addr + ADDR_W'(1);
            end
            E_G_RD:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Record builders
    always_comb
    begin
        rec_rej        = '0;
        rec_rej.kind   = KIND_REJECT;
        rec_rej.status = code_reg;
        rec_rej.last   = 1'b1;

        rec_sum                 = '0;
        rec_sum.kind            = enh_reg ? KIND_ENH : KIND_BASIC;
        rec_sum.status          = ev.hdr[2][2:0] & STATUS_MASK;
        rec_sum.moving_distance = {ev.hdr[4], ev.hdr[3]};
        rec_sum.moving_energy   = ev.hdr[5];
        rec_sum.still_distance  = {ev.hdr[7], ev.hdr[6]};
        rec_sum.still_energy    = ev.hdr[8];
        rec_sum.detect_distance = {ev.hdr[10], ev.hdr[9]};
        rec_sum.light_level     = enh_reg ? light_reg : 8'd0;
        rec_sum.out_level       = enh_reg ? outlvl_reg : 8'd0;
        rec_sum.last            = !enh_reg;

        rec_gate             = '0;
        rec_gate.kind        = still_reg ? KIND_STILL : KIND_MOVING;
        rec_gate.gate_index  = gidx_reg;
        rec_gate.gate_energy = rd_data;
        rec_gate.last        = gate_last;
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            out_valid_reg <= 1'b0;
            out_rec_reg   <= '0;
            code_reg      <= '0;
            enh_reg       <= 1'b0;
            light_reg     <= '0;
            outlvl_reg    <= '0;
            gptr_reg      <= '0;
            gidx_reg      <= '0;
            still_reg     <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                E_IDLE:
                begin
                    if (ev.fire)
                    begin
                        code_reg <= ev.code;
                        enh_reg  <= ev.enh;
                        if (ev.reject)
                        begin
                            state_reg <= E_REJ;
                        end
                        else if (ev.enh)
                        begin
                            state_reg <= E_L_RD;
                        end
                        else
                        begin
                            state_reg <= E_SUM;
                        end
                    end
                end
                E_REJ:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_rec_reg   <= rec_rej;
                        state_reg     <= E_IDLE;
                    end
                end
                E_L_RD:
                begin
                    state_reg <= E_L_CAP;
                end
                E_L_CAP:
                begin
                    light_reg <= rd_data;
                    state_reg <= E_O_CAP;
                end
                E_O_CAP:
                begin
                    outlvl_reg <= rd_data;
                    state_reg  <= E_SUM;
                end
                E_SUM:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_rec_reg   <= rec_sum;
                        gptr_reg      <= ADDR_W'(HDR_BYTES);
                        gidx_reg      <= '0;
                        still_reg     <= 1'b0;
                        state_reg     <= enh_reg ? E_G_RD : E_IDLE;
                    end
                end
                E_G_RD:
                begin
                    state_reg <= E_G_OUT;
                end
                E_G_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_rec_reg   <= rec_gate;
                        gptr_reg      <= gptr_reg + ADDR_W'(1);
                        if (gate_last)
                        begin
                            state_reg <= E_IDLE;
                        end
                        else
                        begin
                            state_reg <= E_G_RD;
                            if (!still_reg && gidx_reg == ev.nm)
                            begin
                                still_reg <= 1'b1;
                                gidx_reg  <= '0;
                            end
                            else
                            begin
                                gidx_reg <= gidx_reg + GATE_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != E_IDLE);
    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

endmodule

// ----- design/rrfp_checker.sv -----
// ============================================================================
// rrfp_checker
// Port-level checks on the radar report frame parser, bound to the top level.
// ============================================================================
module rrfp_checker
    import rrfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // Reject and basic summary words stand alone
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_REJECT || m_axis_tuser == KIND_BASIC)
            |-> m_axis_tlast)
        else $error("single-word record without last");

    // Enhanced summary always has gate words behind it
    a_enh_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ENH |-> !m_axis_tlast)
        else $error("enhanced summary marked last");

    // No new byte taken right after an enhanced summary leaves
    a_enh_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_ENH |=> !s_axis_tready)
        else $error("input taken while gate words pending");

    // Gate index stays within the clamp
    a_gate_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_MOVING || m_axis_tuser == KIND_STILL)
            |-> m_axis_tdata[86:83] <= GATE_W'(MAX_GATE))
        else $error("gate index out of range");

endmodule

bind radar_report_frame_parser rrfp_checker u_rrfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
